FILE: design/rgbhsl_pkg.sv
// shared types, widths and constants of the rgb to hsl converter
package rgbhsl_pkg;

   // field widths
   localparam int CHAN_W    = 8;
   localparam int FRAC_W    = 16;
   localparam int SUM_W     = CHAN_W + 1;
   localparam int SAT_DIV_W = CHAN_W;
   localparam int SAT_NUM_W = SAT_DIV_W + FRAC_W;
   localparam int HUE_DIV_W = 11;

   // quotient bits, one divider stage per bit
   localparam int QUOT_W = FRAC_W;

   // arithmetic constants
   localparam int HALF_SUM     = 255;
   localparam int FULL_SUM     = 510;
   localparam int HUE_OFF_WRAP = 6;
   localparam int HUE_OFF_GRN  = 2;
   localparam int HUE_OFF_BLU  = 4;

   // default queue depths
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 32;

   // channel holding the maximum, first in red, green, blue order
   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic [FRAC_W-1:0]    lightness;
      logic                 grey;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [SAT_DIV_W-1:0] sat_den;
      logic [HUE_DIV_W-1:0] hue_acc;
      logic [HUE_DIV_W-1:0] hue_den;
   } mid_item_type;

   // finished result
   typedef struct packed {
      logic [FRAC_W-1:0] hue;
      logic [FRAC_W-1:0] saturation;
      logic [FRAC_W-1:0] lightness;
   } res_item_type;

endpackage

FILE: design/rgbhsl_fifo.sv
// first-in first-out queue with show-ahead read, depth at least 2
module rgbhsl_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");

   // a lone push grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

FILE: design/rgbhsl_front.sv
// front end: classifies each pixel and queues the divider operands
module rgbhsl_front #(
   parameter int MID_DEPTH = rgbhsl_pkg::MID_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rgbhsl_pkg::CHAN_W-1:0]    req_red,
   input  logic [rgbhsl_pkg::CHAN_W-1:0]    req_green,
   input  logic [rgbhsl_pkg::CHAN_W-1:0]    req_blue,
   output logic                             mid_empty,
   input  logic                             mid_pop,
   output rgbhsl_pkg::mid_item_type         mid_item
);

   localparam int CW = rgbhsl_pkg::CHAN_W;
   localparam int SW = rgbhsl_pkg::SUM_W;
   localparam int HW = rgbhsl_pkg::HUE_DIV_W;
   localparam int FW = rgbhsl_pkg::FRAC_W;
   localparam int NW = rgbhsl_pkg::SAT_NUM_W;

   rgbhsl_pkg::mid_item_type cls_item;
   logic [$bits(rgbhsl_pkg::mid_item_type)-1:0] q_rdata;

   // max, min, sum and difference, then the divider operands
   always_comb begin
      logic [CW-1:0]        mx, mn, d;
      logic [SW-1:0]        sum, den;
      logic [SW+CW-1:0]     lig_x257;
      logic [HW-1:0]        base, plus, minus;
      rgbhsl_pkg::chan_type sel;

      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;

      if (mx == req_red) begin
         sel = rgbhsl_pkg::CH_RED;
      end else if (mx == req_green) begin
         sel = rgbhsl_pkg::CH_GREEN;
      end else begin
         sel = rgbhsl_pkg::CH_BLUE;
      end

      sum = {1'b0, mx} + {1'b0, mn};
      d   = mx - mn;
      den = (sum > SW'(rgbhsl_pkg::HALF_SUM)) ? SW'(rgbhsl_pkg::FULL_SUM) - sum : sum;

      // sum * 65535 / 510 is sum * 257 / 2
      lig_x257 = {sum, {CW{1'b0}}} + {{CW{1'b0}}, sum};

      // hue numerator off*d + num, never negative
      case (sel)
         rgbhsl_pkg::CH_RED: begin
            base  = (req_green < req_blue) ? HW'(rgbhsl_pkg::HUE_OFF_WRAP) * HW'(d) : '0;
            plus  = HW'(req_green);
            minus = HW'(req_blue);
         end
         rgbhsl_pkg::CH_GREEN: begin
            base  = HW'(rgbhsl_pkg::HUE_OFF_GRN) * HW'(d);
            plus  = HW'(req_blue);
            minus = HW'(req_red);
         end
         rgbhsl_pkg::CH_BLUE: begin
            base  = HW'(rgbhsl_pkg::HUE_OFF_BLU) * HW'(d);
            plus  = HW'(req_red);
            minus = HW'(req_green);
         end
         default: begin
            base  = '0;
            plus  = '0;
            minus = '0;
         end
      endcase

      cls_item.lightness = lig_x257[FW:1];
      cls_item.grey      = (d == '0);
      cls_item.sat_num   = {d, {FW{1'b0}}} - NW'(d);
      cls_item.sat_den   = den[CW-1:0];
      cls_item.hue_acc   = base + plus - minus;
      cls_item.hue_den   = HW'(rgbhsl_pkg::HUE_OFF_WRAP) * HW'(d);
   end

   // queue between front and back
   rgbhsl_fifo #(
      .WIDTH ($bits(rgbhsl_pkg::mid_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (cls_item),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (q_rdata)
   );

   assign mid_item = rgbhsl_pkg::mid_item_type'(q_rdata);

endmodule

FILE: design/rgbhsl_divider.sv
// pipelined restoring divider, one quotient bit per stage
// the partial remainder starts below the divisor, so the quotient fits
module rgbhsl_divider #(
   parameter int W = rgbhsl_pkg::SAT_DIV_W
) (
   input  logic                          clock,
   input  logic [W-1:0]                  rem_init,
   input  logic [rgbhsl_pkg::QUOT_W-1:0] low_bits,
   input  logic [W-1:0]                  divisor,
   output logic [rgbhsl_pkg::QUOT_W-1:0] quotient
);

   localparam int QW = rgbhsl_pkg::QUOT_W;

   logic [W-1:0]  rem_ff [QW];
   logic [W-1:0]  rem_in [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] low_in [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] quo_in [QW];
   logic [W-1:0]  div_ff [QW];
   logic [W-1:0]  div_in [QW];

   // one trial subtraction per stage
   always_comb begin
      logic [W-1:0]  rem_p, div_p;
      logic [QW-1:0] low_p, quo_p;
      logic [W:0]    trial;
      logic          ge;
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            rem_p = rem_init;
            low_p = low_bits;
            quo_p = '0;
            div_p = divisor;
         end else begin
            rem_p = rem_ff[s-1];
            low_p = low_ff[s-1];
            quo_p = quo_ff[s-1];
            div_p = div_ff[s-1];
         end
         trial     = {rem_p, low_p[QW-1]};
         ge        = (trial >= {1'b0, div_p});
         rem_in[s] = ge ? W'(trial - {1'b0, div_p}) : trial[W-1:0];
         low_in[s] = {low_p[QW-2:0], 1'b0};
         quo_in[s] = {quo_p[QW-2:0], ge};
         div_in[s] = div_p;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QW; s++) begin
         rem_ff[s] <= rem_in[s];
         low_ff[s] <= low_in[s];
         quo_ff[s] <= quo_in[s];
         div_ff[s] <= div_in[s];
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

FILE: design/rgbhsl_back.sv
// back end: saturation and hue dividers, result queue and issue credit
module rgbhsl_back #(
   parameter int OUT_DEPTH = rgbhsl_pkg::OUT_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_empty,
   output logic                          mid_pop,
   input  rgbhsl_pkg::mid_item_type      mid_item,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_hue,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_saturation,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_lightness
);

   localparam int QW = rgbhsl_pkg::QUOT_W;
   localparam int FW = rgbhsl_pkg::FRAC_W;
   localparam int RW = $clog2(OUT_DEPTH + 1);

   logic          launch;
   logic          rsp_taken;
   logic [RW-1:0] reserved_ff, reserved_in;
   logic          vld_ff  [QW];
   logic          grey_ff [QW];
   logic [FW-1:0] lig_ff  [QW];
   logic [FW-1:0] hue_q, sat_q;
   logic          out_full;
   rgbhsl_pkg::res_item_type res_item, out_item;
   logic [$bits(rgbhsl_pkg::res_item_type)-1:0] out_rdata;

   // issue only with a result slot reserved downstream
   assign launch    = ~mid_empty & (reserved_ff < RW'(OUT_DEPTH));
   assign mid_pop   = launch;
   assign rsp_taken = rsp_pop & ~rsp_empty;

   always_comb begin
      case ({launch, rsp_taken})
         2'b10:   reserved_in = reserved_ff + 1'b1;
         2'b01:   reserved_in = reserved_ff - 1'b1;
         default: reserved_in = reserved_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   // saturation divider
   rgbhsl_divider #(
      .W (rgbhsl_pkg::SAT_DIV_W)
   ) u_sat_div (
      .clock    (clock),
      .rem_init (mid_item.sat_num[rgbhsl_pkg::SAT_NUM_W-1:FW]),
      .low_bits (mid_item.sat_num[FW-1:0]),
      .divisor  (mid_item.sat_den),
      .quotient (sat_q)
   );

   // hue divider
   rgbhsl_divider #(
      .W (rgbhsl_pkg::HUE_DIV_W)
   ) u_hue_div (
      .clock    (clock),
      .rem_init (mid_item.hue_acc),
      .low_bits ('0),
      .divisor  (mid_item.hue_den),
      .quotient (hue_q)
   );

   // valid line alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= launch;
         for (int s = 1; s < QW; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // lightness and grey flag ride along
   always_ff @(posedge clock) begin
      lig_ff[0]  <= mid_item.lightness;
      grey_ff[0] <= mid_item.grey;
      for (int s = 1; s < QW; s++) begin
         lig_ff[s]  <= lig_ff[s-1];
         grey_ff[s] <= grey_ff[s-1];
      end
   end

   // grey pixels carry no hue or saturation
   always_comb begin
      res_item.hue        = grey_ff[QW-1] ? '0 : hue_q;
      res_item.saturation = grey_ff[QW-1] ? '0 : sat_q;
      res_item.lightness  = lig_ff[QW-1];
   end

   // result queue
   rgbhsl_fifo #(
      .WIDTH ($bits(rgbhsl_pkg::res_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (vld_ff[QW-1]),
      .full  (out_full),
      .wdata (res_item),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_rdata)
   );

   assign out_item       = rgbhsl_pkg::res_item_type'(out_rdata);
   assign rsp_hue        = out_item.hue;
   assign rsp_saturation = out_item.saturation;
   assign rsp_lightness  = out_item.lightness;

   // reservation guarantees room for every finished transaction
   assert property (@(posedge clock) disable iff (reset) vld_ff[QW-1] |-> !out_full)
      else $error("result arrived at a full queue");

   // reservations never exceed the queue
   assert property (@(posedge clock) disable iff (reset) reserved_ff <= RW'(OUT_DEPTH))
      else $error("reservation count beyond result queue depth");

   // nothing reserved means nothing waiting
   assert property (@(posedge clock) disable iff (reset) (reserved_ff == '0) |-> rsp_empty)
      else $error("result waiting without a reservation");

endmodule

FILE: design/rgb_to_hsl_converter.sv
// top level of the rgb to hsl converter
//
//  channel | direction | handshake              | fields
//  --------+-----------+------------------------+------------------------------------------
//  req     | in        | req_push / req_full    | req_red, req_green, req_blue (8 b each)
//  rsp     | out       | rsp_pop / rsp_empty    | rsp_hue, rsp_saturation, rsp_lightness
//
//  one pixel per clock sustained while rsp_pop keeps taking results; each transaction is independent
//  from accept to result shown a pixel passes the front queue, the 16 divider stages
//  (one quotient bit each) and the result queue write
//  reset clears the queues, the reservation count and the divider valid line
//  req_full rises once MID_DEPTH pixels wait in the front queue
//  the back issues only while fewer than OUT_DEPTH results are in flight or waiting
module rgb_to_hsl_converter #(
   parameter int MID_DEPTH = rgbhsl_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH = rgbhsl_pkg::OUT_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rgbhsl_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbhsl_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbhsl_pkg::CHAN_W-1:0] req_blue,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_hue,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_saturation,
   output logic [rgbhsl_pkg::FRAC_W-1:0] rsp_lightness
);

   logic                     mid_empty;
   logic                     mid_pop;
   rgbhsl_pkg::mid_item_type mid_item;

   // classify and queue
   rgbhsl_front #(
      .MID_DEPTH (MID_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_item  (mid_item)
   );

   // divide and deliver
   rgbhsl_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .mid_empty      (mid_empty),
      .mid_pop        (mid_pop),
      .mid_item       (mid_item),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

endmodule
